// ===== sv/sha_pkg.sv =====
// ============================================================================
// SHA-256 / SHA-224 package
// Round constants, initial hash values and round functions of the engine.
// ============================================================================
package sha_pkg;

   localparam int WordWidth = 32;
   localparam int NumRounds = 64;
   localparam int BlockWords = 16;
   localparam int HashWords = 8;

   typedef logic [WordWidth-1:0] word_type;

   typedef enum logic {
      MODE_SHA256 = 1'b0,
      MODE_SHA224 = 1'b1
   } mode_type;

   localparam word_type RoundK [NumRounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type Init256 [HashWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type Init224 [HashWords] = '{
      32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
      32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
   };

   localparam word_type PadWord = 32'h80000000;

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (WordWidth - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

// ===== sv/sha256_hash_engine.sv =====
// ============================================================================
// SHA-256 / SHA-224 hash engine
// Gathers big-endian message words into 512-bit blocks, pads the message on
// its last word and compresses each block with one shared round unit.
// ============================================================================
//
//  Channel   Direction  Transfers
//  req_*     in         one message word (tdata: word, valid bytes; tlast)
//  rsp_*     out        one digest word (tdata: word, index; tlast)
//  csr_*     in         digest mode write, no handshake
//
// A word that completes a block starts its compression in the shared round
// unit (ST_ROUND), after which the result is added into the hash state
// (ST_ADD). A last word is followed by the padding words (ST_PAD), the
// rounds and addition of each padded block, then 8 or 7 digest transfers
// that output stalls can hold. Reset is synchronous and selects SHA-256.
// req_tready is low from a block's start to its end, while padding and
// during the digest transfers.
module sha256_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] message_word, [34:32] valid_bytes, [39:35] zero
   input  logic [39:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] digest_word, [34:32] word_index, [39:35] zero
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import sha_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic              mode_ff, mode_in;
   word_type          hash_ff [HashWords];
   word_type          hash_in [HashWords];
   word_type          v_ff [HashWords];
   word_type          v_in [HashWords];
   word_type          w_ff [BlockWords];
   word_type          w_in [BlockWords];
   logic [3:0]        fill_ff, fill_in;
   logic [63:0]       bits_ff, bits_in;
   logic [5:0]        round_ff, round_in;
   logic              padding_ff, padding_in;
   logic              need_len_ff, need_len_in;
   logic [2:0]        out_idx_ff, out_idx_in;
   // Set once the length words go into the block that closes the message.
   logic              len_sent_ff, len_sent_in;

   logic              take;
   logic [2:0]        vb;
   word_type          in_word;
   word_type          t1, t2, w_next, push_val;
   logic              do_push;
   logic [2:0]        last_idx;

   assign take    = req_tvalid && req_tready;
   assign in_word = req_tdata[31:0];
   assign vb      = (req_tdata[34:32] > 3'd4) ? 3'd4 : req_tdata[34:32];
   assign last_idx = (mode_ff == MODE_SHA224) ? 3'd6 : 3'd7;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {5'd0, out_idx_ff, hash_ff[out_idx_ff]};
   assign rsp_tlast  = (out_idx_ff == last_idx);

   assign t1 = v_ff[7] + big_sigma1(v_ff[4])
             + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + RoundK[round_ff] + w_ff[0];
   assign t2 = big_sigma0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   assign w_next = small_sigma1(w_ff[14]) + w_ff[9] + small_sigma0(w_ff[1]) + w_ff[0];

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      hash_in     = hash_ff;
      v_in        = v_ff;
      w_in        = w_ff;
      fill_in     = fill_ff;
      bits_in     = bits_ff;
      round_in    = round_ff;
      padding_in  = padding_ff;
      need_len_in = need_len_ff;
      out_idx_in  = out_idx_ff;
      len_sent_in = len_sent_ff;
      do_push     = 1'b0;
      push_val    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               do_push = 1'b1;
               if (!req_tlast) begin
                  push_val = in_word;
                  bits_in  = bits_ff + 64'd32;
               end else begin
                  bits_in    = bits_ff + {58'd0, vb, 3'd0};
                  padding_in = 1'b1;
                  case (vb)
                     3'd0:    push_val = PadWord;
                     3'd1:    push_val = {in_word[31:24], 24'h800000};
                     3'd2:    push_val = {in_word[31:16], 16'h8000};
                     3'd3:    push_val = {in_word[31:8], 8'h80};
                     default: push_val = in_word;
                  endcase
                  need_len_in = (vb == 3'd4);
               end
            end
         end
         ST_PAD: begin
            do_push = 1'b1;
            if (need_len_ff) begin
               push_val    = PadWord;
               need_len_in = 1'b0;
            end else if (fill_ff == 4'd14) begin
               push_val    = bits_ff[63:32];
               len_sent_in = 1'b1;
            end else if (fill_ff == 4'd15 && len_sent_ff) begin
               push_val = bits_ff[31:0];
            end else begin
               push_val = '0;
            end
         end
         ST_ROUND: begin
            v_in[0] = t1 + t2;
            for (int i = 1; i < HashWords; i++) begin
               v_in[i] = v_ff[i-1];
            end
            v_in[4] = v_ff[3] + t1;
            for (int i = 0; i < BlockWords - 1; i++) begin
               w_in[i] = w_ff[i+1];
            end
            w_in[BlockWords-1] = w_next;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'(NumRounds - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < HashWords; i++) begin
               hash_in[i] = hash_ff[i] + v_ff[i];
            end
            if (!padding_ff) begin
               state_in = ST_IDLE;
            end else if (fill_ff == 4'd0 && !need_len_ff && len_sent_ff) begin
               state_in   = ST_OUT;
               out_idx_in = '0;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (rsp_tlast) begin
                  state_in    = ST_IDLE;
                  padding_in  = 1'b0;
                  len_sent_in = 1'b0;
                  hash_in     = (mode_ff == MODE_SHA224) ? Init224 : Init256;
                  bits_in     = '0;
                  fill_in     = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (do_push) begin
         w_in[fill_ff] = push_val;
         fill_in = fill_ff + 4'd1;
         if (fill_ff == 4'd15) begin
            state_in = ST_ROUND;
            round_in = '0;
            v_in     = hash_ff;
         end else if (state_ff == ST_IDLE && take && req_tlast) begin
            state_in = ST_PAD;
         end
      end

      if (csr_wr_en) begin
         mode_in     = csr_wr_data;
         hash_in     = csr_wr_data ? Init224 : Init256;
         fill_in     = '0;
         bits_in     = '0;
         padding_in  = 1'b0;
         need_len_in = 1'b0;
         len_sent_in = 1'b0;
         state_in    = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         mode_ff     <= MODE_SHA256;
         hash_ff     <= Init256;
         fill_ff     <= '0;
         bits_ff     <= '0;
         round_ff    <= '0;
         padding_ff  <= 1'b0;
         need_len_ff <= 1'b0;
         out_idx_ff  <= '0;
         len_sent_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         mode_ff     <= mode_in;
         hash_ff     <= hash_in;
         fill_ff     <= fill_in;
         bits_ff     <= bits_in;
         round_ff    <= round_in;
         padding_ff  <= padding_in;
         need_len_ff <= need_len_in;
         out_idx_ff  <= out_idx_in;
         len_sent_ff <= len_sent_in;
      end
      v_ff <= v_in;
      w_ff <= w_in;
   end

`ifndef SYNTHESIS
   a_round_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == 6'd63 && !csr_wr_en) |=> (state_ff == ST_ADD))
      else $error("round sequence did not end after 64 rounds");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("input ready while busy");
   a_out_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (padding_ff && len_sent_ff))
      else $error("digest output before length block");
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (out_idx_ff == last_idx))
      else $error("digest end index wrong");
`endif

endmodule

// ===== dv/tb_sha256_hash_engine.sv =====
// ============================================================================
// SHA-256 / SHA-224 hash engine testbench
// Streams messages into the engine and compares each digest transfer with a
// behavioral hash computed in the bench, under both digest modes and random
// idling on the input and output channels.
// ============================================================================
`timescale 1ns / 100ps

module tb_sha256_hash_engine;
   import sha_pkg::*;

   localparam int StallLimit = 20000;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  nbytes;
      logic        last;
   } msg_item_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_item_type;

   typedef struct {
      msg_item_type item;
      logic         has_digest0;
      logic [31:0]  digest0;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;

   mode_type        hash_mode;
   word_type        state_words [HashWords];
   word_type        block_words [BlockWords];
   int              block_fill;
   logic [63:0]     bit_total;
   digest_item_type digest_queue [$];
   int              fail_count = 0;
   int              idle_cycles = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              recv_hold = 0;
   logic            recv_hold_req = 1'b0;

   sha256_hash_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic word_type ror32(word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic restart_message();
      for (int i = 0; i < HashWords; i++) begin
         state_words[i] = (hash_mode == MODE_SHA224) ? Init224[i] : Init256[i];
      end
      block_fill = 0;
      bit_total = '0;
   endtask

   task automatic compress_block();
      word_type sched [NumRounds];
      word_type v [HashWords];
      word_type t1, t2, s0, s1;
      for (int t = 0; t < BlockWords; t++) sched[t] = block_words[t];
      for (int t = BlockWords; t < NumRounds; t++) begin
         s0 = ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3);
         s1 = ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10);
         sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
      end
      for (int i = 0; i < HashWords; i++) v[i] = state_words[i];
      for (int t = 0; t < NumRounds; t++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + sched[t];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int i = 7; i > 0; i--) v[i] = v[i-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < HashWords; i++) state_words[i] += v[i];
   endtask

   task automatic append_word(word_type w);
      block_words[block_fill] = w;
      block_fill++;
      if (block_fill == BlockWords) begin
         compress_block();
         block_fill = 0;
      end
   endtask

   // Models each message word; for a last word, queues the digest words it produces.
   task automatic predict_digest(msg_item_type it);
      int nb, count, sh;
      digest_item_type d;
      if (!it.last) begin
         append_word(it.word);
         bit_total += 64'd32;
         return;
      end
      nb = (it.nbytes > 4) ? 4 : it.nbytes;
      bit_total += 64'(nb * 8);
      if (nb == 4) begin
         append_word(it.word);
         append_word(PadWord);
      end else begin
         sh = 8 * (4 - nb);
         append_word(((sh >= 32) ? 32'h0 : ((it.word >> sh) << sh)) | (32'h80 << (sh - 8)));
      end
      if (block_fill > 14) while (block_fill != 0) append_word('0);
      while (block_fill < 14) append_word('0);
      append_word(bit_total[63:32]);
      append_word(bit_total[31:0]);
      count = (hash_mode == MODE_SHA224) ? 7 : 8;
      for (int k = 0; k < count; k++) begin
         d.word = state_words[k];
         d.index = k[2:0];
         d.last = (k == count - 1);
         digest_queue.push_back(d);
      end
      restart_message();
   endtask

   task automatic send_item(msg_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, it.nbytes, it.word};
      req_tlast <= it.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_digest(it);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_mode(mode_type m);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      hash_mode = m;
      restart_message();
   endtask

   task automatic send_random_message(int max_words);
      msg_item_type it;
      int n;
      n = $urandom_range(max_words);
      for (int i = 0; i < n; i++) begin
         it.word = $urandom;
         it.nbytes = 3'($urandom_range(7));
         it.last = 1'b0;
         send_item(it);
      end
      it.word = $urandom;
      it.nbytes = ($urandom_range(3) == 0) ? 3'd4 : 3'($urandom_range(7));
      it.last = 1'b1;
      send_item(it);
   endtask

   // Receiver: random stalls plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_hold_req && recv_hold < 3000) begin
         recv_hold <= recv_hold + 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      digest_item_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast};
         if (digest_queue.size() == 0) begin
            $display("%0t: unexpected digest transfer, actual %h", $time, got);
            fail_count++;
         end else begin
            want = digest_queue.pop_front();
            if (got.word !== want.word)
               $display("%0t: digest word expected %h actual %h", $time, want.word, got.word);
            if (got.index !== want.index)
               $display("%0t: word index expected %0d actual %0d", $time, want.index, got.index);
            if (got.last !== want.last)
               $display("%0t: tlast expected %b actual %b", $time, want.last, got.last);
            if (got !== want) fail_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   stim_row_type directed_rows [] = '{
      // Empty SHA-256 message.
      '{'{32'h0, 3'd0, 1'b1}, 1'b1, 32'he3b0c442},
      // "abc" as a three-byte last word, junk in the tail byte.
      '{'{32'h616263ff, 3'd3, 1'b1}, 1'b1, 32'hba7816bf},
      '{'{32'hffffffff, 3'd4, 1'b1}, 1'b0, 32'h0},
      '{'{32'hffffffff, 3'd7, 1'b1}, 1'b0, 32'h0},
      '{'{32'h12345678, 3'd1, 1'b1}, 1'b0, 32'h0},
      '{'{32'h12345678, 3'd2, 1'b1}, 1'b0, 32'h0},
      '{'{32'h00000000, 3'd5, 1'b0}, 1'b0, 32'h0},
      '{'{32'hffffffff, 3'd0, 1'b0}, 1'b0, 32'h0},
      '{'{32'haaaaaaaa, 3'd6, 1'b1}, 1'b0, 32'h0}
   };

   initial begin
      msg_item_type it;
      int first_idx;
      hash_mode = MODE_SHA256;
      restart_message();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         send_item(directed_rows[r].item);
         if (directed_rows[r].has_digest0) begin
            first_idx = digest_queue.size() - HashWords;
            if (digest_queue[first_idx].word !== directed_rows[r].digest0) begin
               $display("%0t: first digest word expected %h actual %h", $time,
                        directed_rows[r].digest0, digest_queue[first_idx].word);
               fail_count++;
            end
         end
      end
      // Remainders of 55 to 67 bytes: one or two padding blocks.
      for (int len = 13; len <= 16; len++) begin
         for (int i = 0; i < len; i++) begin
            it.word = $urandom;
            it.nbytes = 3'd4;
            it.last = 1'b0;
            send_item(it);
         end
         it.word = $urandom;
         it.nbytes = 3'd3;
         it.last = 1'b1;
         send_item(it);
      end

      write_mode(MODE_SHA224);
      it = '{32'h0, 3'd0, 1'b1};
      send_item(it);
      send_random_message(20);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 59 : 0;
         recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 23 : 0;
         write_mode((phase == 1) ? MODE_SHA224 : MODE_SHA256);
         if (phase == 2) recv_hold_req = 1'b1;
         for (int m = 0; m < 14; m++) begin
            send_random_message((m == 5) ? 40 : 12);
            if (m == 6) wait_drained();
         end
         recv_hold_req = 1'b0;
      end
      write_mode(MODE_SHA256);
      // Abandon a message in progress with a mode write.
      it = '{32'hdeadbeef, 3'd4, 1'b0};
      send_item(it);
      write_mode(MODE_SHA224);
      send_random_message(6);

      wait_drained();
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/sha_pkg.sv
sv/sha256_hash_engine.sv
dv/tb_sha256_hash_engine.sv
